// ===== hw/rtl/skvt_pkg.sv =====
package skvt_pkg;
	localparam int Capacity = 256;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = IdxW + 1;
	localparam int KeyW = 32;
	localparam int ValW = 32;
	localparam logic [KeyW-1:0] ReservedKey = '1;

	typedef enum logic [3:0] {
		FN_INSERT = 4'd0, FN_SET = 4'd1, FN_FIND = 4'd2, FN_ERASE = 4'd3,
		FN_KEY_OF_VAL = 4'd4, FN_ERASE_VAL = 4'd5, FN_UNUSED = 4'd6,
		FN_CLEAR = 4'd7, FN_LAST = 4'd8
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_DUP = 3'd1, ST_RESERVED = 3'd2, ST_FULL = 3'd3, ST_NOTFOUND = 3'd4
	} status_t;

	// per-cell shift command: hold, load new, take left neighbor, take right neighbor
	typedef enum logic [1:0] {
		CM_HOLD = 2'd0, CM_LOAD = 2'd1, CM_FROM_LO = 2'd2, CM_FROM_HI = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
	} entry_t;

	// per-cell compare flags
	typedef struct packed {
		logic lt;
		logic eq;
		logic veq;
		logic ideq;
	} flags_t;
endpackage

// ===== hw/rtl/sorted_key_value_table_core.sv =====
// Sorted key/value table, 256 entries, built as a row of cells that compare
// the request against every entry in parallel and shift in one step.
// A request is captured, then compared, priority-selected and written to the
// cells as its result is registered; busy is high through the strobe and
// start is taken again the cycle after the strobe. One result per request on
// result_valid for one cycle; the receiver cannot stall and must take it.
module sorted_key_value_table_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [3:0]                func,
	input  logic [skvt_pkg::KeyW-1:0] key,
	input  logic [skvt_pkg::ValW-1:0] value,
	output logic                      result_valid,
	output logic [2:0]                status,
	output logic                      found,
	output logic [skvt_pkg::KeyW-1:0] key_out,
	output logic [skvt_pkg::ValW-1:0] value_out
);
	import skvt_pkg::*;

	logic              act_q;
	logic [3:0]        func_q;
	logic [KeyW-1:0]   key_q;
	logic [ValW-1:0]   val_q;
	logic [CntW-1:0]   cnt_q;
	entry_t            ent [Capacity];
	flags_t            fl [Capacity];
	cmd_t              cmd [Capacity];
	logic              setv [Capacity];

	logic [CntW-1:0]   lb, vpos, upos;
	logic              keq, vhit, do_ins, do_rm, do_set;
	logic [IdxW-1:0]   pos;

	// lower bound: entries below count sorted, so first entry not below key
	always_comb begin
		lb = cnt_q;
		vpos = cnt_q;
		upos = cnt_q;
		keq = 1'b0;
		for (int i = Capacity - 1; i >= 0; i--) begin
			if (CntW'(i) < cnt_q) begin
				if (!fl[i].lt) lb = CntW'(i);
				if (fl[i].eq) keq = 1'b1;
				if (fl[i].veq) vpos = CntW'(i);
				if (!fl[i].ideq) upos = CntW'(i);
			end
		end
	end

	always_comb begin
		vhit = vpos < cnt_q;
		do_ins = act_q && func_q == FN_INSERT && key_q != ReservedKey && !keq
			&& cnt_q < CntW'(Capacity);
		do_set = act_q && func_q == FN_SET && keq;
		do_rm = act_q && ((func_q == FN_ERASE && keq) || (func_q == FN_ERASE_VAL && vhit));
		pos = (func_q == FN_ERASE_VAL) ? vpos[IdxW-1:0] : lb[IdxW-1:0];
	end

	for (genvar g = 0; g < Capacity; g++) begin : g_cell
		always_comb begin
			cmd[g] = CM_HOLD;
			setv[g] = do_set && lb[IdxW-1:0] == IdxW'(g);
			if (do_ins) begin
				if (IdxW'(g) == pos) cmd[g] = CM_LOAD;
				else if (IdxW'(g) > pos) cmd[g] = CM_FROM_LO;
			end else if (do_rm && IdxW'(g) >= pos) begin
				cmd[g] = CM_FROM_HI;
			end
		end
		skvt_cell u_cell (
			.clk(clk), .idx(IdxW'(g)), .cmd(cmd[g]), .set_val(setv[g]),
			.new_e({key_q, val_q}),
			.lo_e(ent[(g == 0) ? 0 : g - 1]),
			.hi_e(ent[(g == Capacity - 1) ? g : g + 1]),
			.cmp_key(key_q), .cmp_val(val_q), .e(ent[g]), .flags(fl[g])
		);
	end

	assign busy = act_q || result_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			result_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			result_valid <= act_q;
			act_q <= start && !busy;
			if (do_ins) cnt_q <= cnt_q + 1'b1;
			else if (do_rm) cnt_q <= cnt_q - 1'b1;
			else if (act_q && func_q == FN_CLEAR) cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q <= func;
			key_q <= key;
			val_q <= value;
		end
		if (act_q) begin
			status <= ST_NOTFOUND;
			found <= 1'b0;
			key_out <= '0;
			value_out <= '0;
			case (func_q)
				FN_INSERT: begin
					if (key_q == ReservedKey) status <= ST_RESERVED;
					else if (keq) begin status <= ST_DUP; found <= 1'b1; end
					else if (!do_ins) status <= ST_FULL;
					else begin status <= ST_OK; found <= 1'b1; end
				end
				FN_SET: if (keq) begin status <= ST_OK; found <= 1'b1; end
				FN_FIND, FN_ERASE: if (keq) begin
					status <= ST_OK; found <= 1'b1;
					value_out <= ent[lb[IdxW-1:0]].value;
				end
				FN_KEY_OF_VAL, FN_ERASE_VAL: begin
					if (vhit) begin
						status <= ST_OK; found <= 1'b1;
						key_out <= ent[vpos[IdxW-1:0]].key;
						if (func_q == FN_ERASE_VAL) value_out <= ent[vpos[IdxW-1:0]].value;
					end else key_out <= ReservedKey;
				end
				FN_UNUSED: begin status <= ST_OK; found <= 1'b1; key_out <= KeyW'(upos); end
				FN_CLEAR: begin status <= ST_OK; found <= 1'b1; end
				FN_LAST: if (cnt_q != '0) begin
					status <= ST_OK; found <= 1'b1;
					value_out <= ent[IdxW'(cnt_q - 1'b1)].value;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/skvt_cell.sv =====
module skvt_cell (
	input  logic                        clk,
	input  logic [skvt_pkg::IdxW-1:0]   idx,
	input  skvt_pkg::cmd_t              cmd,
	input  logic                        set_val,
	input  skvt_pkg::entry_t            new_e,
	input  skvt_pkg::entry_t            lo_e,
	input  skvt_pkg::entry_t            hi_e,
	input  logic [skvt_pkg::KeyW-1:0]   cmp_key,
	input  logic [skvt_pkg::ValW-1:0]   cmp_val,
	output skvt_pkg::entry_t            e,
	output skvt_pkg::flags_t            flags
);
	import skvt_pkg::*;
	entry_t e_q;

	always_ff @(posedge clk) begin
		if (set_val) begin
			e_q.value <= new_e.value;
		end else begin
			case (cmd)
				CM_LOAD:    e_q <= new_e;
				CM_FROM_LO: e_q <= lo_e;
				CM_FROM_HI: e_q <= hi_e;
				default:    e_q <= e_q;
			endcase
		end
	end

	assign e = e_q;
	assign flags.lt = e_q.key < cmp_key;
	assign flags.eq = e_q.key == cmp_key;
	assign flags.veq = e_q.value == cmp_val;
	assign flags.ideq = e_q.key == KeyW'(idx);
endmodule

// ===== tb/sorted_key_value_table_core_test.sv =====
`timescale 1ns / 1ps

module sorted_key_value_table_core_test;
	import skvt_pkg::*;

	typedef struct {
		logic [3:0]      func;
		logic [KeyW-1:0] key;
		logic [ValW-1:0] value;
		int              gap;
		bit              drain;
	} request_t;

	typedef struct {
		logic [2:0]      status;
		logic            found;
		logic [KeyW-1:0] key_out;
		logic [ValW-1:0] value_out;
	} response_t;

	localparam int CycleLimit = 400000;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [3:0]      func;
	logic [KeyW-1:0] key;
	logic [ValW-1:0] value;
	logic            result_valid;
	logic [2:0]      status;
	logic            found;
	logic [KeyW-1:0] key_out;
	logic [ValW-1:0] value_out;

	request_t  pending_requests[$];
	response_t expected_responses[$];
	int        errors = 0;
	int        cycles = 0;
	bit        stimulus_done = 0;

	logic [KeyW-1:0] table_keys[$];
	logic [ValW-1:0] table_values[$];

	sorted_key_value_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .key(key), .value(value),
		.result_valid(result_valid), .status(status), .found(found),
		.key_out(key_out), .value_out(value_out)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int key_slot(logic [KeyW-1:0] k);
		int p;
		p = 0;
		while (p < table_keys.size() && table_keys[p] < k)
			p++;
		return p;
	endfunction

	function automatic int value_slot(logic [ValW-1:0] v);
		foreach (table_values[i])
			if (table_values[i] == v)
				return i;
		return table_values.size();
	endfunction

	function automatic response_t apply_request(request_t rq);
		response_t r;
		int p;
		int n;
		r = '{ST_NOTFOUND, 1'b0, '0, '0};
		n = table_keys.size();
		case (rq.func)
			FN_INSERT: begin
				if (rq.key == ReservedKey) begin
					r.status = ST_RESERVED;
				end else begin
					p = key_slot(rq.key);
					if (p < n && table_keys[p] == rq.key) begin
						r.status = ST_DUP;
						r.found = 1;
					end else if (n >= Capacity) begin
						r.status = ST_FULL;
					end else begin
						table_keys.insert(p, rq.key);
						table_values.insert(p, rq.value);
						r.status = ST_OK;
						r.found = 1;
					end
				end
			end
			FN_SET, FN_FIND, FN_ERASE: begin
				p = key_slot(rq.key);
				if (p < n && table_keys[p] == rq.key) begin
					r.status = ST_OK;
					r.found = 1;
					if (rq.func == FN_SET) begin
						table_values[p] = rq.value;
					end else begin
						r.value_out = table_values[p];
						if (rq.func == FN_ERASE) begin
							table_keys.delete(p);
							table_values.delete(p);
						end
					end
				end
			end
			FN_KEY_OF_VAL, FN_ERASE_VAL: begin
				p = value_slot(rq.value);
				if (p < n) begin
					r.key_out = table_keys[p];
					r.status = ST_OK;
					r.found = 1;
					if (rq.func == FN_ERASE_VAL) begin
						r.value_out = table_values[p];
						table_keys.delete(p);
						table_values.delete(p);
					end
				end else begin
					r.key_out = ReservedKey;
				end
			end
			FN_UNUSED: begin
				p = 0;
				while (p < n && table_keys[p] == p)
					p++;
				r.key_out = p;
				r.status = ST_OK;
				r.found = 1;
			end
			FN_CLEAR: begin
				table_keys.delete();
				table_values.delete();
				r.status = ST_OK;
				r.found = 1;
			end
			FN_LAST: begin
				if (n > 0) begin
					r.value_out = table_values[n-1];
					r.status = ST_OK;
					r.found = 1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// acceptance of a transaction, sampled at the rising edge
	logic busy_at_edge = 1'b1;

	// driver
	request_t cur;
	int       wait_left = 0;
	bit       have_cur = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_at_edge) begin
				start <= 1'b0;
				have_cur = 0;
			end
			if (!have_cur && pending_requests.size() > 0 && !(start && !busy_at_edge)) begin
				cur = pending_requests.pop_front();
				have_cur = 1;
				wait_left = cur.gap;
			end
			if (have_cur && !start) begin
				if (cur.drain && expected_responses.size() > 0) begin
				end else if (wait_left > 0) begin
					wait_left--;
				end else begin
					func <= cur.func;
					key <= cur.key;
					value <= cur.value;
					start <= 1'b1;
				end
			end
			if (!have_cur && !start && pending_requests.size() == 0)
				stimulus_done = 1;
		end
	end

	always @(posedge clk) begin
		busy_at_edge <= busy;
		if (arst_n && start && !busy)
			expected_responses.push_back(apply_request(cur));
	end

	// monitor
	response_t exp_r;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid) begin
			if (expected_responses.size() == 0) begin
				$display("%0t: unexpected transaction status=%0d found=%0d key_out=%h value_out=%h",
					$time, status, found, key_out, value_out);
				errors++;
			end else begin
				exp_r = expected_responses.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
					errors++;
				end
				if (found !== exp_r.found) begin
					$display("%0t: found expected %0d actual %0d", $time, exp_r.found, found);
					errors++;
				end
				if (key_out !== exp_r.key_out) begin
					$display("%0t: key_out expected %h actual %h", $time, exp_r.key_out, key_out);
					errors++;
				end
				if (value_out !== exp_r.value_out) begin
					$display("%0t: value_out expected %h actual %h",
						$time, exp_r.value_out, value_out);
					errors++;
				end
			end
		end
	end

	function automatic logic [KeyW-1:0] pick_key(int mode);
		case (mode)
			0: return $urandom_range(0, 15);
			1: return $urandom_range(0, 300);
			2: return ReservedKey - $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	task automatic add_request(logic [3:0] f, logic [KeyW-1:0] k, logic [ValW-1:0] v,
			bit d = 0);
		request_t rq;
		rq.func = f;
		rq.key = k;
		rq.value = v;
		rq.drain = d;
		rq.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
		pending_requests.push_back(rq);
	endtask

	initial begin
		int mode;
		int r;
		logic [3:0] f;
		logic [ValW-1:0] v;
		arst_n = 0;
		start = 0;
		func = '0;
		key = '0;
		value = '0;

		add_request(FN_LAST, 0, 0);
		add_request(FN_UNUSED, 0, 0);
		add_request(FN_FIND, 5, 0);
		add_request(FN_INSERT, ReservedKey, 1);
		add_request(FN_INSERT, 0, '1);
		add_request(FN_INSERT, 0, 3);
		add_request(FN_INSERT, 1, 0);
		add_request(FN_INSERT, ReservedKey - 1, 32'h5555_aaaa);
		add_request(FN_UNUSED, 0, 0);
		add_request(FN_SET, 1, 32'haaaa_5555);
		add_request(FN_SET, ReservedKey, 4);
		add_request(FN_FIND, 1, 0);
		add_request(FN_ERASE, ReservedKey, 0);
		add_request(FN_KEY_OF_VAL, 0, 32'haaaa_5555);
		add_request(FN_KEY_OF_VAL, 0, 99);
		add_request(FN_ERASE_VAL, 0, '1);
		add_request(FN_ERASE_VAL, 0, '1);
		add_request(FN_UNUSED, 0, 0);
		add_request(FN_LAST, 0, 0);
		add_request(4'd9, '1, '1);
		add_request(4'd15, 0, 0);
		add_request(FN_ERASE, ReservedKey - 1, 0);
		add_request(FN_CLEAR, 0, 0, 1);
		add_request(FN_LAST, 0, 0);

		// fill to capacity, then overflow
		for (int i = 0; i < Capacity; i++)
			add_request(FN_INSERT, (i * 7) % Capacity, $urandom());
		add_request(FN_INSERT, 1000, 1);
		add_request(FN_INSERT, 14, 1);
		add_request(FN_UNUSED, 0, 0);
		add_request(FN_LAST, 0, 0);
		add_request(FN_CLEAR, 0, 0);

		for (int i = 0; i < 1450; i++) begin
			if (i % 300 == 150) begin
				add_request(FN_CLEAR, 0, 0, 1);
				continue;
			end
			mode = (i / 100) % 4;
			r = $urandom_range(0, 99);
			if (r < 40) f = FN_INSERT;
			else if (r < 90) f = 4'($urandom_range(1, 8));
			else f = 4'($urandom_range(0, 15));
			if (f == FN_CLEAR && $urandom_range(0, 9) != 0)
				f = FN_FIND;
			v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom();
			add_request(f, pick_key(mode), v);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	initial begin
		wait (stimulus_done && expected_responses.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_responses.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		wait (cycles >= CycleLimit);
		$display("TEST FAILED");
		$finish;
	end
endmodule
